/* rtl/gcdlcm_pkg.sv */
// ----------------------------------------------------------------------------
// gcdlcm_pkg
// Shared types, step numbers and the control program of the gcd/lcm sequencer.
// ----------------------------------------------------------------------------
package gcdlcm_pkg;

    localparam int STEP_BITS = 4;

    typedef logic [STEP_BITS-1:0] step_t;

    // micro-operations of the sequencer
    typedef enum logic [2:0] {
        OP_FETCH,
        OP_ZERO_CHECK,
        OP_TEST_SMALL,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_SWAP,
        OP_MUL,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t   op;
        logic  div_lcm;  // divider source: 0 big/small, 1 first operand/gcd
        step_t target;   // jump destination
    } ctrl_word_t;

    // program addresses
    localparam step_t STEP_FETCH      = 4'd0;
    localparam step_t STEP_ZERO_CHECK = 4'd1;
    localparam step_t STEP_TEST       = 4'd2;
    localparam step_t STEP_EU_LOAD    = 4'd3;
    localparam step_t STEP_EU_DIV     = 4'd4;
    localparam step_t STEP_SWAP       = 4'd5;
    localparam step_t STEP_LCM_LOAD   = 4'd6;
    localparam step_t STEP_LCM_DIV    = 4'd7;
    localparam step_t STEP_MUL        = 4'd8;
    localparam step_t STEP_EMIT       = 4'd9;

    function automatic ctrl_word_t program_rom(input step_t pc);
        ctrl_word_t w;
        unique case (pc)
            STEP_FETCH:      w = '{OP_FETCH,      1'b0, STEP_FETCH};
            STEP_ZERO_CHECK: w = '{OP_ZERO_CHECK, 1'b0, STEP_EMIT};
            STEP_TEST:       w = '{OP_TEST_SMALL, 1'b0, STEP_LCM_LOAD};
            STEP_EU_LOAD:    w = '{OP_DIV_LOAD,   1'b0, STEP_FETCH};
            STEP_EU_DIV:     w = '{OP_DIV_STEP,   1'b0, STEP_FETCH};
            STEP_SWAP:       w = '{OP_SWAP,       1'b0, STEP_TEST};
            STEP_LCM_LOAD:   w = '{OP_DIV_LOAD,   1'b1, STEP_FETCH};
            STEP_LCM_DIV:    w = '{OP_DIV_STEP,   1'b1, STEP_FETCH};
            STEP_MUL:        w = '{OP_MUL,        1'b0, STEP_FETCH};
            STEP_EMIT:       w = '{OP_EMIT,       1'b0, STEP_FETCH};
            default:         w = '{OP_FETCH,      1'b0, STEP_FETCH};
        endcase
        return w;
    endfunction

endpackage

/* rtl/gcd_lcm_calculator.sv */
// ----------------------------------------------------------------------------
// gcd_lcm_calculator
// Euclidean gcd and lcm of two unsigned operands, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Takes two unsigned OPERAND_BITS-bit operands per item and returns their
// greatest common divisor and least common multiple (2*OPERAND_BITS bits).
// If either operand is zero, gcd is the other operand and lcm is zero.
// Control is a ten-step program in a small rom: a step counter walks it and
// each control word drives one plain datapath around a single restoring
// divider that retires one quotient bit per cycle. Euclid's loop runs the
// divider once per remainder, then once more for first_value / gcd, and a
// single OPERAND_BITS x OPERAND_BITS multiply forms the lcm. An item with
// a zero operand skips from the zero check straight to the emit step;
// otherwise the number k of remainder steps grows at most about
// 1.44*OPERAND_BITS (worst on consecutive fibonacci numbers). One item is
// worked on at a time; a finished result sits in the output register so
// the next item can start while it waits on m_tready.
// ----------------------------------------------------------------------------
module gcd_lcm_calculator
    import gcdlcm_pkg::*;
#(
    parameter int OPERAND_BITS = 31
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // fields from bit 0: first_value, second_value
    input  logic [((2*OPERAND_BITS+7)/8)*8-1:0]        s_tdata,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // fields from bit 0: gcd_value, lcm_value
    output logic [((3*OPERAND_BITS+7)/8)*8-1:0]        m_tdata
);

    localparam int W         = OPERAND_BITS;
    localparam int OUT_DATA_W = ((3*OPERAND_BITS+7)/8)*8;
    localparam int CNT_W     = $clog2(OPERAND_BITS+1);

    // sequencer
    step_t      pc_reg, pc_next;
    ctrl_word_t cw;

    // operand and euclid registers
    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] b_reg, b_next;
    logic [W-1:0] big_reg, big_next;
    logic [W-1:0] small_reg, small_next;

    // shared restoring divider
    logic [W-1:0]     div_den_reg, div_den_next;
    logic [W-1:0]     div_rem_reg, div_rem_next;
    logic [W-1:0]     div_quo_reg, div_quo_next;
    logic [CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [W:0]       shift_rem;
    logic [W+1:0]     trial;
    logic             div_last;

    // finished result and output register
    logic [W-1:0]   res_gcd_reg, res_gcd_next;
    logic [2*W-1:0] res_lcm_reg, res_lcm_next;
    logic [W-1:0]   out_gcd_reg, out_gcd_next;
    logic [2*W-1:0] out_lcm_reg, out_lcm_next;
    logic           out_valid_reg, out_valid_next;

    logic [W-1:0] in_first;
    logic [W-1:0] in_second;
    logic         out_free;

    assign cw        = program_rom(pc_reg);
    assign in_first  = s_tdata[W-1:0];
    assign in_second = s_tdata[2*W-1:W];

    // one quotient bit per cycle
    assign shift_rem = {div_rem_reg, div_quo_reg[W-1]};
    assign trial     = {1'b0, shift_rem} - {2'b00, div_den_reg};
    assign div_last  = (div_cnt_reg == CNT_W'(1));

    assign out_free  = !out_valid_reg || m_tready;

    assign s_tready  = (cw.op == OP_FETCH);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = OUT_DATA_W'({out_lcm_reg, out_gcd_reg});

    always_comb begin
        pc_next        = pc_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        big_next       = big_reg;
        small_next     = small_reg;
        div_den_next   = div_den_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        div_cnt_next   = div_cnt_reg;
        res_gcd_next   = res_gcd_reg;
        res_lcm_next   = res_lcm_reg;
        out_gcd_next   = out_gcd_reg;
        out_lcm_next   = out_lcm_reg;
        out_valid_next = out_valid_reg && !m_tready;

        unique case (cw.op)
            OP_FETCH: begin
                // take the operands, ordered as larger and smaller
                if (s_tvalid) begin
                    a_next = in_first;
                    b_next = in_second;
                    if (in_first > in_second) begin
                        big_next   = in_first;
                        small_next = in_second;
                    end else begin
                        big_next   = in_second;
                        small_next = in_first;
                    end
                    pc_next = pc_reg + step_t'(1);
                end
            end
            OP_ZERO_CHECK: begin
                // a zero operand skips the whole loop
                if (a_reg == '0 || b_reg == '0) begin
                    res_gcd_next = a_reg | b_reg;
                    res_lcm_next = '0;
                    pc_next      = cw.target;
                end else begin
                    pc_next = pc_reg + step_t'(1);
                end
            end
            OP_TEST_SMALL: begin
                // remainder zero: big holds the gcd
                if (small_reg == '0) begin
                    pc_next = cw.target;
                end else begin
                    pc_next = pc_reg + step_t'(1);
                end
            end
            OP_DIV_LOAD: begin
                div_quo_next = cw.div_lcm ? a_reg : big_reg;
                div_den_next = cw.div_lcm ? big_reg : small_reg;
                div_rem_next = '0;
                div_cnt_next = CNT_W'(W);
                pc_next      = pc_reg + step_t'(1);
            end
            OP_DIV_STEP: begin
                if (!trial[W+1]) begin
                    div_rem_next = trial[W-1:0];
                    div_quo_next = {div_quo_reg[W-2:0], 1'b1};
                end else begin
                    div_rem_next = shift_rem[W-1:0];
                    div_quo_next = {div_quo_reg[W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg - CNT_W'(1);
                if (div_last) begin
                    pc_next = pc_reg + step_t'(1);
                end
            end
            OP_SWAP: begin
                big_next   = small_reg;
                small_next = div_rem_reg;
                pc_next    = cw.target;
            end
            OP_MUL: begin
                // lcm = (first / gcd) * second
                res_gcd_next = big_reg;
                res_lcm_next = {{W{1'b0}}, div_quo_reg} * {{W{1'b0}}, b_reg};
                pc_next      = pc_reg + step_t'(1);
            end
            OP_EMIT: begin
                if (out_free) begin
                    out_gcd_next   = res_gcd_reg;
                    out_lcm_next   = res_lcm_reg;
                    out_valid_next = 1'b1;
                    pc_next        = cw.target;
                end
            end
            default: begin
                pc_next = STEP_FETCH;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= STEP_FETCH;
            out_valid_reg <= 1'b0;
        end else begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        big_reg     <= big_next;
        small_reg   <= small_next;
        div_den_reg <= div_den_next;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        div_cnt_reg <= div_cnt_next;
        res_gcd_reg <= res_gcd_next;
        res_lcm_reg <= res_lcm_next;
        out_gcd_reg <= out_gcd_next;
        out_lcm_reg <= out_lcm_next;
    end

`ifndef ASSERT_OFF
    // the divider never runs on a zero divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cw.op == OP_DIV_STEP) |-> (div_den_reg != '0))
        else $error("divider running with zero divisor");

    // partial remainder stays below the divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cw.op == OP_DIV_STEP) |-> (div_rem_reg < div_den_reg))
        else $error("partial remainder not below divisor");

    // euclid pair stays ordered at every test
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cw.op == OP_TEST_SMALL) |-> (big_reg >= small_reg))
        else $error("euclid pair out of order");

    // an accepted item goes straight to the zero check
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (pc_reg == STEP_ZERO_CHECK))
        else $error("sequencer did not advance after accept");

    // a new result only appears out of the emit step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(pc_reg == STEP_EMIT))
        else $error("result raised outside emit step");
`endif

endmodule
